>>> sv/ats_pkg.sv
// ----------------------------------------------------------------------------
// ats_pkg: shared types and constants for angle_to_step_rate
// Field widths, register indexes, fixed scale factors and the structs that
// pass configuration and per-request status between the pipeline modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ats_pkg;

  // Configuration register widths.
  localparam int unsigned CPR_W   = 16;
  localparam int unsigned ANGLE_W = 9;
  localparam int unsigned RPM_W   = 12;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned ADDR_W  = 2;

  // Result field widths.
  localparam int unsigned PERIOD_W = 26;
  localparam int unsigned HALF_W   = 25;

  // Internal arithmetic widths.
  // Dividend 500000 * max_angle_deg fits 28 bits for any 9-bit angle.
  localparam int unsigned NUM_W  = 28;
  // 3 * max_rpm needs 14 bits; divisor 3 * max_rpm * remainder needs 30 bits.
  localparam int unsigned RPM3_W = 14;
  localparam int unsigned DEN_W  = 30;
  // Both sides of the tilt limit compare fit 25 bits.
  localparam int unsigned LIM_W  = 25;

  // Scale factors: 60e6 us/min over 360 deg, times 3 on the divisor side.
  localparam int unsigned STEP_SCALE  = 500000;
  localparam int unsigned DEG_PER_REV = 360;

  // Reset values of the configuration registers.
  localparam logic [CPR_W-1:0]   CPR_RESET   = CPR_W'(400);
  localparam logic [ANGLE_W-1:0] ANGLE_RESET = ANGLE_W'(50);
  localparam logic [RPM_W-1:0]   RPM_RESET   = RPM_W'(400);

  // Largest representable step period.
  localparam logic [NUM_W-1:0] PERIOD_MAX = NUM_W'(2 ** PERIOD_W - 1);

  // Configuration register indexes.
  typedef enum logic [ADDR_W-1:0] {
    REG_COUNTS_PER_REV = 2'd0,
    REG_MAX_ANGLE_DEG  = 2'd1,
    REG_MAX_RPM        = 2'd2
  } ats_reg_t;

  // Configuration as seen by the datapath, with precomputed products.
  typedef struct packed {
    logic [CPR_W-1:0]  cpr;
    logic [NUM_W-1:0]  num;
    logic [RPM3_W-1:0] rpm3;
    logic [LIM_W-1:0]  lim;
  } ats_cfg_t;

  // Sign information that travels with the remainder pipeline.
  typedef struct packed {
    logic neg;
    logic nz;
  } ats_sign_t;

  // Result flags that travel with the period divider.
  typedef struct packed {
    logic dir;
    logic active;
  } ats_res_t;

endpackage

`default_nettype wire

>>> sv/angle_to_step_rate.sv
// ----------------------------------------------------------------------------
// angle_to_step_rate: encoder count to stepper step period
// Reduces a signed encoder count to an angle within one revolution and turns
// it into a step period, half period and direction for a stepper driver.
// ----------------------------------------------------------------------------
// Usage: a request is taken on every clock edge where start is high and busy
// is low; busy is high only during reset, so one request per cycle is taken.
// Each request produces exactly one result, shown for one cycle with done
// high, after it passes the entry and magnitude registers, the remainder
// pipeline, the limit register, the period divider and the output register.
// Results cannot be held back, so the receiver must capture them on done.
// The remainder pipeline has one position bit per stage and the period divider
// one quotient bit per stage, 28 stages. Write the configuration registers only when no request is in flight.
`default_nettype none

module angle_to_step_rate
  import ats_pkg::*;
#(
  parameter int unsigned POSITION_WIDTH = 32
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  // Request side.
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [POSITION_WIDTH-1:0] position,
  // Result side.
  output logic                           done,
  output logic                           direction,
  output logic                           active,
  output logic [PERIOD_W-1:0]            step_period_us,
  output logic [HALF_W-1:0]              half_period_us,
  // Configuration write port.
  input  wire logic                      cfg_wr_en,
  input  wire logic [ADDR_W-1:0]         cfg_addr,
  input  wire logic [CFG_W-1:0]          cfg_wdata
);

  localparam int unsigned W = POSITION_WIDTH;

  ats_cfg_t         cfg;

  logic             in_v;
  logic [W-1:0]     in_raw;

  logic             mag_v;
  logic [W-1:0]     mag;
  ats_sign_t        mag_sign;

  logic             rem_v;
  logic [CPR_W-1:0] rem_out;
  ats_sign_t        rem_sign;

  logic [LIM_W-1:0] prod360;
  logic             lmt_v;
  logic [DEN_W-1:0] lmt_den;
  ats_res_t         lmt_res;
  ats_res_t         lmt_res_next;

  logic             div_v;
  logic [NUM_W-1:0] div_quo;
  ats_res_t         div_res;
  logic [NUM_W-1:0] period_next;

  // The pipeline never stalls; requests are refused only in reset.
  assign busy = rst;

  ats_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Entry register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else begin
      in_v <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    in_raw <= position;
  end

  // Magnitude and sign of the position.
  always_ff @(posedge clk) begin
    if (rst) begin
      mag_v <= 1'b0;
    end else begin
      mag_v <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    mag          <= in_raw[W-1] ? W'('0 - in_raw) : in_raw;
    mag_sign.neg <= in_raw[W-1];
    mag_sign.nz  <= (in_raw != '0);
  end

  ats_rem_pipe #(
    .POSITION_WIDTH (W)
  ) u_rem (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mag_v),
    .in_mag    (mag),
    .in_sign   (mag_sign),
    .divisor   (cfg.cpr),
    .out_valid (rem_v),
    .out_rem   (rem_out),
    .out_sign  (rem_sign)
  );

  // Tilt limit test, direction, and the divisor 3 * max_rpm * |r|.
  // With zero counts per revolution the remainder is the low CPR_W bits of the magnitude.
  assign prod360 = LIM_W'(rem_out) * LIM_W'(DEG_PER_REV);

  always_comb begin
    lmt_res_next.active = (rem_out != '0) && (cfg.cpr != '0) && (cfg.rpm3 != '0) &&
                          (prod360 < cfg.lim);
    lmt_res_next.dir    = !(rem_sign.neg &&
                            ((cfg.cpr != '0) ? (rem_out != '0) : rem_sign.nz));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lmt_v <= 1'b0;
    end else begin
      lmt_v <= rem_v;
    end
  end

  always_ff @(posedge clk) begin
    lmt_den <= DEN_W'(cfg.rpm3) * DEN_W'(rem_out);
    lmt_res <= lmt_res_next;
  end

  ats_div_pipe u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (lmt_v),
    .in_den    (lmt_den),
    .in_res    (lmt_res),
    .num       (cfg.num),
    .out_valid (div_v),
    .out_quo   (div_quo),
    .out_res   (div_res)
  );

  // Saturate the period and clear it when the motor is stopped.
  always_comb begin
    if (!div_res.active) begin
      period_next = '0;
    end else if (div_quo > PERIOD_MAX) begin
      period_next = PERIOD_MAX;
    end else begin
      period_next = div_quo;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= div_v;
    end
  end

  always_ff @(posedge clk) begin
    direction      <= div_res.dir;
    active         <= div_res.active;
    step_period_us <= period_next[PERIOD_W-1:0];
    half_period_us <= period_next[PERIOD_W-1:1];
  end

endmodule

`default_nettype wire

>>> sv/ats_cfg.sv
// ----------------------------------------------------------------------------
// ats_cfg: configuration registers
// Holds the three writable registers and derives the constant dividend,
// the scaled speed and the tilt limit used by the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module ats_cfg
  import ats_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_wr_en,
  input  wire logic [ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_W-1:0]  cfg_wdata,
  output ats_cfg_t               cfg
);

  logic [CPR_W-1:0]   counts_per_rev;
  logic [ANGLE_W-1:0] max_angle_deg;
  logic [RPM_W-1:0]   max_rpm;
  logic [NUM_W-1:0]   num;
  logic [RPM3_W-1:0]  rpm3;
  logic [LIM_W-1:0]   lim;

  // Register writes; unused indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      counts_per_rev <= CPR_RESET;
      max_angle_deg  <= ANGLE_RESET;
      max_rpm        <= RPM_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_COUNTS_PER_REV: counts_per_rev <= cfg_wdata[CPR_W-1:0];
        REG_MAX_ANGLE_DEG:  max_angle_deg  <= cfg_wdata[ANGLE_W-1:0];
        REG_MAX_RPM:        max_rpm        <= cfg_wdata[RPM_W-1:0];
        default: ;
      endcase
    end
  end

  // Derived products follow the registers in the cycle after. The user must
  // change configuration only while no request is in flight; the block does
  // not enforce it. Products then settle long before requests use them.
  always_ff @(posedge clk) begin
    num  <= NUM_W'(max_angle_deg) * NUM_W'(STEP_SCALE);
    rpm3 <= (RPM3_W'(max_rpm) << 1) + RPM3_W'(max_rpm);
    lim  <= LIM_W'(max_angle_deg) * LIM_W'(counts_per_rev);
  end

  assign cfg.cpr  = counts_per_rev;
  assign cfg.num  = num;
  assign cfg.rpm3 = rpm3;
  assign cfg.lim  = lim;

endmodule

`default_nettype wire

>>> sv/ats_rem_pipe.sv
// ----------------------------------------------------------------------------
// ats_rem_pipe: pipelined remainder of the position magnitude
// Restoring division with one dividend bit per stage, POSITION_WIDTH stages.
// Only the remainder is kept; the sign flags travel alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module ats_rem_pipe
  import ats_pkg::*;
#(
  parameter int unsigned POSITION_WIDTH = 32
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  input  wire logic [POSITION_WIDTH-1:0] in_mag,
  input  ats_sign_t                      in_sign,
  input  wire logic [CPR_W-1:0]          divisor,
  output logic                           out_valid,
  output logic [CPR_W-1:0]               out_rem,
  output ats_sign_t                      out_sign
);

  localparam int unsigned W = POSITION_WIDTH;

  logic             vld  [W];
  logic [CPR_W-1:0] rem  [W];
  logic [W-1:0]     dvd  [W];
  ats_sign_t        sgn  [W];

  for (genvar k = 0; k < W; k++) begin : g_stage
    logic             pv;
    logic [CPR_W-1:0] pr;
    logic [W-1:0]     pd;
    ats_sign_t        ps;
    logic [CPR_W:0]   sh;
    logic             ge;

    // Stage inputs come from the previous stage, or from the entry.
    if (k == 0) begin : g_first
      assign pv = in_valid;
      assign pr = '0;
      assign pd = in_mag;
      assign ps = in_sign;
    end else begin : g_next
      assign pv = vld[k-1];
      assign pr = rem[k-1];
      assign pd = dvd[k-1];
      assign ps = sgn[k-1];
    end

    // Bring down the next dividend bit and subtract when it fits.
    assign sh = {pr, pd[W-1]};
    assign ge = (sh >= {1'b0, divisor});

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else begin
        vld[k] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      rem[k] <= ge ? CPR_W'(sh - {1'b0, divisor}) : sh[CPR_W-1:0];
      dvd[k] <= pd << 1;
      sgn[k] <= ps;
    end
  end

  assign out_valid = vld[W-1];
  assign out_rem   = rem[W-1];
  assign out_sign  = sgn[W-1];

endmodule

`default_nettype wire

>>> sv/ats_div_pipe.sv
// ----------------------------------------------------------------------------
// ats_div_pipe: pipelined step period divider
// Divides the configured dividend by the per-request divisor, one quotient
// bit per stage over NUM_W stages, each reading its dividend bit directly;
// the user, not the block, keeps it constant while requests are in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module ats_div_pipe
  import ats_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire logic [DEN_W-1:0] in_den,
  input  ats_res_t              in_res,
  input  wire logic [NUM_W-1:0] num,
  output logic                  out_valid,
  output logic [NUM_W-1:0]      out_quo,
  output ats_res_t              out_res
);

  logic             vld [NUM_W];
  logic [DEN_W-1:0] rem [NUM_W];
  logic [DEN_W-1:0] den [NUM_W];
  logic [NUM_W-1:0] quo [NUM_W];
  ats_res_t         res [NUM_W];

  for (genvar j = 0; j < NUM_W; j++) begin : g_stage
    logic             pv;
    logic [DEN_W-1:0] pr;
    logic [DEN_W-1:0] pdn;
    logic [NUM_W-1:0] pq;
    ats_res_t         pres;
    logic [DEN_W:0]   sh;
    logic             ge;

    if (j == 0) begin : g_first
      assign pv   = in_valid;
      assign pr   = '0;
      assign pdn  = in_den;
      assign pq   = '0;
      assign pres = in_res;
    end else begin : g_next
      assign pv   = vld[j-1];
      assign pr   = rem[j-1];
      assign pdn  = den[j-1];
      assign pq   = quo[j-1];
      assign pres = res[j-1];
    end

    // One restoring step on dividend bit NUM_W-1-j.
    assign sh = {pr, num[NUM_W-1-j]};
    assign ge = (sh >= {1'b0, pdn});

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j] <= 1'b0;
      end else begin
        vld[j] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      rem[j] <= ge ? DEN_W'(sh - {1'b0, pdn}) : sh[DEN_W-1:0];
      den[j] <= pdn;
      quo[j] <= {pq[NUM_W-2:0], ge};
      res[j] <= pres;
    end
  end

  assign out_valid = vld[NUM_W-1];
  assign out_quo   = quo[NUM_W-1];
  assign out_res   = res[NUM_W-1];

endmodule

`default_nettype wire

>>> sv/ats_checker.sv
// ----------------------------------------------------------------------------
// ats_checker: port-level checks for angle_to_step_rate
// Watches requests and results at the top level ports and checks the fixed
// latency and the consistency of the result fields.
// ----------------------------------------------------------------------------
`default_nettype none

module ats_checker
  import ats_pkg::*;
#(
  parameter int unsigned POSITION_WIDTH = 32
) (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                start,
  input wire logic                busy,
  input wire logic                done,
  input wire logic                active,
  input wire logic [PERIOD_W-1:0] step_period_us,
  input wire logic [HALF_W-1:0]   half_period_us
);

  localparam int unsigned LATENCY = POSITION_WIDTH + 32;

  // Every request produces a result after the fixed latency.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("request without result after fixed latency");

  // Every result belongs to a request taken the fixed latency before.
  a_no_orphan: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result without matching request");

  // A stopped motor reports zero periods.
  a_stopped_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !active) |-> (step_period_us == '0 && half_period_us == '0))
    else $error("nonzero period while stopped");

  // The half period is the step period shifted down by one.
  a_half: assert property (@(posedge clk) disable iff (rst)
    done |-> (half_period_us == step_period_us[PERIOD_W-1:1]))
    else $error("half period does not match step period");

endmodule

bind angle_to_step_rate ats_checker #(
  .POSITION_WIDTH (POSITION_WIDTH)
) u_ats_checker (.*);

`default_nettype wire

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for angle_to_step_rate
// Sends signed encoder counts through the command interface under several
// register settings, including zero and out-of-range limits. Each result is
// compared field by field with a step rate that the testbench works out on
// its own from the current register values.
// ----------------------------------------------------------------------------
module tb_top;
  import ats_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned POS_W   = 32;
  // Request to result latency of the block.
  localparam int unsigned LATENCY = POS_W + 31;
  localparam longint unsigned PERIOD_LIMIT = (64'd1 << PERIOD_W) - 1;
  localparam int unsigned RANDOM_PHASES = 10;
  localparam int unsigned PHASE_ITEMS   = 105;
  localparam int unsigned PRINT_LIMIT   = 30;

  // One step rate result, together with the count it was computed from.
  typedef struct {
    logic [POS_W-1:0]    pos;
    logic                direction;
    logic                active;
    logic [PERIOD_W-1:0] period;
    logic [HALF_W-1:0]   half;
  } step_rate_t;

  logic                clk;
  logic                rst;
  logic                start;
  logic                busy;
  logic [POS_W-1:0]    position;
  logic                done;
  logic                direction;
  logic                active;
  logic [PERIOD_W-1:0] step_period_us;
  logic [HALF_W-1:0]   half_period_us;
  logic                cfg_wr_en;
  logic [ADDR_W-1:0]   cfg_addr;
  logic [CFG_W-1:0]    cfg_wdata;

  // Register values as the block should hold them.
  logic [CPR_W-1:0]   cpr_cfg;
  logic [ANGLE_W-1:0] angle_cfg;
  logic [RPM_W-1:0]   rpm_cfg;

  step_rate_t pending_rates[$];
  int unsigned error_count = 0;

  angle_to_step_rate #(
    .POSITION_WIDTH(POS_W)
  ) DUT (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .position       (position),
    .done           (done),
    .direction      (direction),
    .active         (active),
    .step_period_us (step_period_us),
    .half_period_us (half_period_us),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata)
  );

  // 12 ns clock.
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Works out the step rate for one encoder count under the current registers.
  function automatic step_rate_t predict_step_rate(input logic [POS_W-1:0] pos);
    step_rate_t res;
    logic [POS_W-1:0] mag_bits;
    longint unsigned mag, rem, period;
    res.pos = pos;
    // Two's complement magnitude; the most negative count keeps its top bit.
    mag_bits = pos[POS_W-1] ? (~pos + 1'b1) : pos;
    mag = 64'(mag_bits);
    // A zero divisor leaves the magnitude as the remainder.
    rem = (cpr_cfg != 0) ? (mag % 64'(cpr_cfg)) : mag;
    period = 0;
    res.active = 1'b0;
    if (rem != 0 && cpr_cfg != 0 && rpm_cfg != 0 &&
        rem * DEG_PER_REV < 64'(angle_cfg) * 64'(cpr_cfg)) begin
      period = (64'(STEP_SCALE) * 64'(angle_cfg)) / (64'd3 * 64'(rpm_cfg) * rem);
      if (period > PERIOD_LIMIT) begin
        period = PERIOD_LIMIT;
      end
      res.active = 1'b1;
    end
    res.direction = (pos[POS_W-1] && rem != 0) ? 1'b0 : 1'b1;
    res.period = period[PERIOD_W-1:0];
    res.half = period[PERIOD_W-1:1];
    return res;
  endfunction

  // Prints one mismatch line (up to a limit) and counts it.
  task automatic report_error(input string msg);
    if (error_count < PRINT_LIMIT) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
    error_count++;
  endtask

  // Results are sampled at the rising edge and checked at the falling edge.
  logic       res_seen;
  step_rate_t res_got;

  always @(posedge clk) begin
    res_seen <= !rst && (done === 1'b1);
    res_got.direction <= direction;
    res_got.active <= active;
    res_got.period <= step_period_us;
    res_got.half <= half_period_us;
  end

  always @(negedge clk) begin
    step_rate_t want;
    if (res_seen) begin
      if (pending_rates.size() == 0) begin
        report_error("result with no request outstanding");
      end else begin
        want = pending_rates.pop_front();
        if (res_got.direction !== want.direction) begin
          report_error($sformatf("position %h direction got %b want %b",
                                 want.pos, res_got.direction, want.direction));
        end
        if (res_got.active !== want.active) begin
          report_error($sformatf("position %h active got %b want %b",
                                 want.pos, res_got.active, want.active));
        end
        if (res_got.period !== want.period) begin
          report_error($sformatf("position %h step_period_us got %0d want %0d",
                                 want.pos, res_got.period, want.period));
        end
        if (res_got.half !== want.half) begin
          report_error($sformatf("position %h half_period_us got %0d want %0d",
                                 want.pos, res_got.half, want.half));
        end
      end
    end
  end

  // Sends one request and records the result it should produce.
  task automatic send_position(input logic [POS_W-1:0] pos);
    @(negedge clk);
    start <= 1'b1;
    position <= pos;
    @(posedge clk);
    while (busy !== 1'b0) begin
      @(posedge clk);
    end
    pending_rates.push_back(predict_step_rate(pos));
  endtask

  // Holds start low for an idle gap of length n, with junk on the position bus.
  task automatic idle_gap(input int unsigned n);
    if (n > 0) begin
      @(negedge clk);
      start <= 1'b0;
      position <= $urandom;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // Mostly short gaps, a few long ones; none at all during a burst.
  function automatic int unsigned pick_gap(input bit burst);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (burst || roll < 55) begin
      return 0;
    end else if (roll < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // Waits until every outstanding request has produced its result.
  task automatic drain_requests();
    @(negedge clk);
    start <= 1'b0;
    while (pending_rates.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic write_reg(input ats_reg_t idx, input logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Rewrites all three registers once the block is idle.
  task automatic set_config(input logic [CPR_W-1:0] cpr, input logic [ANGLE_W-1:0] angle,
                            input logic [RPM_W-1:0] rpm);
    drain_requests();
    write_reg(REG_COUNTS_PER_REV, CFG_W'(cpr));
    write_reg(REG_MAX_ANGLE_DEG, CFG_W'(angle));
    write_reg(REG_MAX_RPM, CFG_W'(rpm));
    cpr_cfg = cpr;
    angle_cfg = angle;
    rpm_cfg = rpm;
  endtask

  // Reset register values: zero angle, both sides of the tilt limit, extremes.
  task automatic test_reset_values();
    logic [POS_W-1:0] list[$];
    list = '{32'd0, 32'd1, -32'sd1, 32'd55, 32'd56, -32'sd55, -32'sd56,
             32'd400, -32'sd401, 32'h7FFF_FFFF, 32'h8000_0000};
    foreach (list[i]) begin
      send_position(list[i]);
      idle_gap(pick_gap(i < 4));
    end
  endtask

  // Zero registers, largest periods and a saturated period.
  task automatic test_special_configs();
    // Zero counts per revolution: stopped, direction from the count's sign.
    set_config(16'd0, 9'd50, 12'd400);
    send_position(32'd5);
    send_position(-32'sd5);
    // Zero tilt limit.
    set_config(16'd400, 9'd0, 12'd400);
    send_position(32'd1);
    // Zero speed.
    set_config(16'd400, 9'd50, 12'd0);
    send_position(32'd1);
    // Limit above a full turn: the period saturates.
    set_config(16'hFFFF, 9'h1FF, 12'd1);
    send_position(32'd1);
    idle_gap(2);
    send_position(-32'sd1);
    send_position(32'd65534);
    // Largest unsaturated period, and a tilt just past the limit.
    set_config(16'hFFFF, 9'd359, 12'd1);
    send_position(32'd1);
    send_position(-32'sd65534);
    // One count per revolution: every remainder is zero.
    set_config(16'd1, 9'd359, 12'hFFF);
    send_position(32'hFFFF_FFFF);
    send_position(32'd12345);
    set_config(CPR_RESET, ANGLE_RESET, RPM_RESET);
  endtask

  // Random position, often near the tilt limit within some revolution.
  function automatic logic [POS_W-1:0] random_position();
    longint lim, turns, offs;
    logic [POS_W-1:0] corner[$];
    corner = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'hFFFF_FFFF, 32'd0, 32'd1};
    lim = (longint'(angle_cfg) * longint'(cpr_cfg)) / DEG_PER_REV;
    turns = longint'($urandom_range(0, 40000)) - 20000;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        offs = longint'($urandom_range(0, 32'(2 * lim + 4))) - (lim + 2);
        return POS_W'(turns * longint'(cpr_cfg) + offs);
      end
      4, 5, 6: return $urandom;
      7: begin
        offs = longint'($urandom_range(0, 1000));
        return $urandom_range(0, 1) ? POS_W'(-offs) : POS_W'(offs);
      end
      8: return corner[$urandom_range(0, corner.size() - 1)];
      default: return POS_W'(turns * longint'(cpr_cfg));
    endcase
  endfunction

  // Random register settings per phase, with random counts and idling.
  task automatic test_random_phases();
    logic [CPR_W-1:0]   cpr;
    logic [ANGLE_W-1:0] angle;
    logic [RPM_W-1:0]   rpm;
    bit burst;
    for (int unsigned ph = 0; ph < RANDOM_PHASES; ph++) begin
      case ($urandom_range(0, 19))
        0: cpr = 16'd0;
        1, 2: cpr = 16'hFFFF;
        3: cpr = 16'd1;
        4, 5, 6, 7, 8: cpr = CPR_W'($urandom_range(1, 64));
        default: cpr = CPR_W'($urandom_range(1, 16'hFFFF));
      endcase
      case ($urandom_range(0, 19))
        0: angle = 9'd0;
        1, 2: angle = 9'd359;
        3: angle = 9'd1;
        4, 5: angle = ANGLE_W'($urandom_range(360, 511));
        default: angle = ANGLE_W'($urandom_range(1, 359));
      endcase
      case ($urandom_range(0, 19))
        0: rpm = 12'd0;
        1, 2: rpm = 12'hFFF;
        3, 4: rpm = 12'd1;
        default: rpm = RPM_W'($urandom_range(1, 12'hFFF));
      endcase
      set_config(cpr, angle, rpm);
      burst = ($urandom_range(0, 3) == 0);
      for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
        send_position(random_position());
        idle_gap(pick_gap(burst));
      end
    end
    drain_requests();
  endtask

  // Run time limit.
  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    rst <= 1'b1;
    start <= 1'b0;
    position <= '0;
    cfg_wr_en <= 1'b0;
    cfg_addr <= REG_COUNTS_PER_REV;
    cfg_wdata <= '0;
    cpr_cfg = CPR_RESET;
    angle_cfg = ANGLE_RESET;
    rpm_cfg = RPM_RESET;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_values();
    test_special_configs();
    test_random_phases();

    // Let any stray result show up before the verdict.
    repeat (LATENCY + 8) @(posedge clk);
    if (pending_rates.size() != 0) begin
      report_error("requests left without a result");
    end
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
